[hdl/tmpl_pkg.sv]
package tmpl_pkg;

  localparam int MAX_ELEMENTS = 4096;
  localparam int MAX_VERTICES = 4096;
  localparam int COORD_W      = 24;
  localparam int ELEM_W       = 13;
  localparam int VERT_W       = 12;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int CROSS_W      = 52;
  localparam int ACC_W        = 80;
  localparam int DIV_W        = ACC_W + 16;
  localparam int BARY_W       = 17;
  localparam int EPOCH_W      = 16;
  localparam int PROD_LAST    = 23;

  // item kinds
  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_SLOT   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // operand selects: short edge vectors, then long cross products
  localparam logic [4:0] SEL_B0  = 5'd0;
  localparam logic [4:0] SEL_B1  = 5'd1;
  localparam logic [4:0] SEL_B2  = 5'd2;
  localparam logic [4:0] SEL_C0  = 5'd3;
  localparam logic [4:0] SEL_C1  = 5'd4;
  localparam logic [4:0] SEL_C2  = 5'd5;
  localparam logic [4:0] SEL_D0  = 5'd6;
  localparam logic [4:0] SEL_D1  = 5'd7;
  localparam logic [4:0] SEL_D2  = 5'd8;
  localparam logic [4:0] SEL_AP0 = 5'd9;
  localparam logic [4:0] SEL_AP1 = 5'd10;
  localparam logic [4:0] SEL_AP2 = 5'd11;
  localparam logic [4:0] SEL_V0  = 5'd12;
  localparam logic [4:0] SEL_V1  = 5'd13;
  localparam logic [4:0] SEL_V2  = 5'd14;
  localparam logic [4:0] SEL_W0  = 5'd15;
  localparam logic [4:0] SEL_W1  = 5'd16;
  localparam logic [4:0] SEL_W2  = 5'd17;

  // accumulation groups, in evaluation order
  localparam logic [3:0] G_V0   = 4'd0;
  localparam logic [3:0] G_V1   = 4'd1;
  localparam logic [3:0] G_V2   = 4'd2;
  localparam logic [3:0] G_VOL1 = 4'd3;
  localparam logic [3:0] G_W0   = 4'd4;
  localparam logic [3:0] G_W1   = 4'd5;
  localparam logic [3:0] G_W2   = 4'd6;
  localparam logic [3:0] G_VOL2 = 4'd7;
  localparam logic [3:0] G_VOL3 = 4'd8;
  localparam logic [3:0] G_DD   = 4'd9;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WBUMP, S_WTOP, S_WCHK, S_SBUMP, S_STOP, S_SCHK,
    S_FETCH, S_PREP, S_EVAL, S_V0, S_NRD, S_NCAP, S_DIVSET, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic [4:0] a_sel;
    logic [4:0] b_sel;
    logic       neg;
    logic       last;
  } prod_t;

  // product schedule of one element evaluation
  function automatic prod_t prod_info(input logic [4:0] pi);
    prod_t r;
    case (pi)
      5'd0:  r = '{SEL_C1,  SEL_D2,  1'b0, 1'b0};
      5'd1:  r = '{SEL_C2,  SEL_D1,  1'b1, 1'b1};
      5'd2:  r = '{SEL_C2,  SEL_D0,  1'b0, 1'b0};
      5'd3:  r = '{SEL_C0,  SEL_D2,  1'b1, 1'b1};
      5'd4:  r = '{SEL_C0,  SEL_D1,  1'b0, 1'b0};
      5'd5:  r = '{SEL_C1,  SEL_D0,  1'b1, 1'b1};
      5'd6:  r = '{SEL_AP0, SEL_V0,  1'b0, 1'b0};
      5'd7:  r = '{SEL_AP1, SEL_V1,  1'b0, 1'b0};
      5'd8:  r = '{SEL_AP2, SEL_V2,  1'b0, 1'b1};
      5'd9:  r = '{SEL_B1,  SEL_AP2, 1'b0, 1'b0};
      5'd10: r = '{SEL_B2,  SEL_AP1, 1'b1, 1'b1};
      5'd11: r = '{SEL_B2,  SEL_AP0, 1'b0, 1'b0};
      5'd12: r = '{SEL_B0,  SEL_AP2, 1'b1, 1'b1};
      5'd13: r = '{SEL_B0,  SEL_AP1, 1'b0, 1'b0};
      5'd14: r = '{SEL_B1,  SEL_AP0, 1'b1, 1'b1};
      5'd15: r = '{SEL_D0,  SEL_W0,  1'b0, 1'b0};
      5'd16: r = '{SEL_D1,  SEL_W1,  1'b0, 1'b0};
      5'd17: r = '{SEL_D2,  SEL_W2,  1'b0, 1'b1};
      5'd18: r = '{SEL_C0,  SEL_W0,  1'b1, 1'b0};
      5'd19: r = '{SEL_C1,  SEL_W1,  1'b1, 1'b0};
      5'd20: r = '{SEL_C2,  SEL_W2,  1'b1, 1'b1};
      5'd21: r = '{SEL_B0,  SEL_V0,  1'b0, 1'b0};
      5'd22: r = '{SEL_B1,  SEL_V1,  1'b0, 1'b0};
      5'd23: r = '{SEL_B2,  SEL_V2,  1'b0, 1'b1};
      default: r = '{SEL_B0, SEL_B0, 1'b0, 1'b1};
    endcase
    return r;
  endfunction

endpackage

[hdl/tetra_mesh_point_locate.sv]
// Tetrahedral mesh point locate: visibility walk with exhaustive fallback scan.
// Loads are written on acceptance; the block stays idle. Each visited element runs up to
// 24 products, each in two halves on one shared 25x27 multiplier, plus fetch; a deleted
// element in the scan is skipped unevaluated. A hit with nonzero volume adds four 17-step
// barycentric divisions, then the result is up for one cycle on done; no new word is
// taken until then. Reset (synchronous, rst high) clears all 4097 visit marks, as does
// a wrap of the query epoch; busy stays high meanwhile and the receiver cannot stall.
module tetra_mesh_point_locate (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tmpl_pkg::ELEM_W-1:0]   cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [tmpl_pkg::ELEM_W-1:0]   index,
  input  logic [1:0]                    slot,
  input  logic signed [tmpl_pkg::COORD_W-1:0] x,
  input  logic signed [tmpl_pkg::COORD_W-1:0] y,
  input  logic signed [tmpl_pkg::COORD_W-1:0] z,
  input  logic [tmpl_pkg::VERT_W-1:0]   corner_vertex,
  input  logic [tmpl_pkg::ELEM_W-1:0]   face_neighbor,
  output logic                          done,
  output logic [tmpl_pkg::ELEM_W-1:0]   found_element,
  output logic [tmpl_pkg::BARY_W-1:0]   bary0,
  output logic [tmpl_pkg::BARY_W-1:0]   bary1,
  output logic [tmpl_pkg::BARY_W-1:0]   bary2,
  output logic [tmpl_pkg::BARY_W-1:0]   bary3
);

  localparam int CW = tmpl_pkg::COORD_W;
  localparam int EW = tmpl_pkg::ELEM_W;
  localparam int AW = tmpl_pkg::ACC_W;
  localparam int XW = tmpl_pkg::CROSS_W;
  localparam int DW = tmpl_pkg::DIV_W;
  localparam int FW = tmpl_pkg::DIFF_W;

  // memories
  logic [3*CW-1:0]                  vert_mem   [tmpl_pkg::MAX_VERTICES];
  logic [tmpl_pkg::VERT_W-1:0]      corner_mem [4][tmpl_pkg::MAX_ELEMENTS+1];
  logic [EW-1:0]                    neigh_mem  [4][tmpl_pkg::MAX_ELEMENTS+1];
  logic [tmpl_pkg::EPOCH_W-1:0]     mark_mem   [tmpl_pkg::MAX_ELEMENTS+1];

  tmpl_pkg::state_t state, state_next, clr_ret;

  logic [EW-1:0]                element_count;
  logic [tmpl_pkg::EPOCH_W-1:0] epoch;
  logic [tmpl_pkg::EPOCH_W-1:0] epoch_inc;
  logic [EW-1:0]                clr_addr;
  logic [EW-1:0]                cur, ne, it;
  logic                         scanning;
  logic signed [CW-1:0]         px, py, pz;
  logic [tmpl_pkg::VERT_W-1:0]  corner_rd [4];
  logic [EW-1:0]                neigh_rd;
  logic [tmpl_pkg::EPOCH_W-1:0] mark_rd;
  logic [3*CW-1:0]              vert_rd;
  logic [3*CW-1:0]              cv [4];
  logic [2:0]                   fj;
  logic [1:0]                   exit_face;

  // evaluation datapath
  logic signed [FW-1:0] sv [12];
  logic signed [XW-1:0] lv [6];
  logic [4:0]           pi;
  logic                 half_sel, issue_done, issue_en;
  tmpl_pkg::prod_t      pinfo;
  logic signed [FW-1:0] a_val;
  logic signed [XW-1:0] b_full;
  logic signed [26:0]   b_part;
  logic signed [XW-1:0] prod, prod_q;
  logic                 tag_valid, tag_neg, tag_hi, tag_last;
  logic [3:0]           g;
  logic signed [AW-1:0] acc, addend, acc_sum;
  logic signed [AW-1:0] vol0, vol1, vol2, vol3, dd;
  logic                 grp_done, check_neg;
  logic [1:0]           v0cnt;

  // division
  logic [DW-1:0]               rem, dsh;
  logic [tmpl_pkg::BARY_W-1:0] q;
  logic [4:0]                  qcnt;
  logic [1:0]                  k;
  logic                        ge;
  logic signed [AW-1:0]        vol_k;
  logic [tmpl_pkg::BARY_W-1:0] bary_q [4];

  logic accept, cur_bad, epoch_wrap;

  function automatic logic signed [FW-1:0] sdiff(input logic [CW-1:0] u,
                                                 input logic [CW-1:0] v);
    return $signed({u[CW-1], u}) - $signed({v[CW-1], v});
  endfunction

  function automatic logic [CW-1:0] axis(input logic [3*CW-1:0] w, input int a);
    logic [CW-1:0] r;
    case (a)
      0:       r = w[3*CW-1:2*CW];
      1:       r = w[2*CW-1:CW];
      default: r = w[CW-1:0];
    endcase
    return r;
  endfunction

  assign accept     = start && !busy;
  assign epoch_inc  = epoch + 1'b1;
  assign epoch_wrap = (epoch_inc == '0);
  assign cur_bad    = (cur == '0) || (cur > EW'(tmpl_pkg::MAX_ELEMENTS));

  // select multiplier operands
  always_comb begin
    pinfo = tmpl_pkg::prod_info(pi);
    a_val = '0;
    b_full = '0;
    for (int i = 0; i < 12; i++) begin
      if (pinfo.a_sel == 5'(i)) a_val = sv[i];
      if (pinfo.b_sel == 5'(i)) b_full = {{(XW-FW){sv[i][FW-1]}}, sv[i]};
    end
    for (int i = 0; i < 6; i++) begin
      if (pinfo.b_sel == 5'(tmpl_pkg::SEL_V0 + 5'(i))) b_full = lv[i];
    end
    b_part = half_sel ? {b_full[XW-1], b_full[XW-1:26]} : {1'b0, b_full[25:0]};
    prod   = a_val * b_part;
  end

  // accumulate registered product
  always_comb begin
    addend   = tag_hi ? {{2{prod_q[XW-1]}}, prod_q, 26'b0}
                      : {{(AW-XW){prod_q[XW-1]}}, prod_q};
    acc_sum  = tag_neg ? acc - addend : acc + addend;
    grp_done = tag_valid && tag_last;
    check_neg = grp_done && acc_sum[AW-1] &&
                (g == tmpl_pkg::G_VOL1 || g == tmpl_pkg::G_VOL2 ||
                 g == tmpl_pkg::G_VOL3);
  end

  // divider step
  always_comb begin
    ge = (rem >= dsh);
    case (k)
      2'd0:    vol_k = vol0;
      2'd1:    vol_k = vol1;
      2'd2:    vol_k = vol2;
      default: vol_k = vol3;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tmpl_pkg::S_CLEAR:
        if (clr_addr == EW'(tmpl_pkg::MAX_ELEMENTS)) state_next = clr_ret;
      tmpl_pkg::S_IDLE:
        if (accept && kind == tmpl_pkg::KIND_QUERY) state_next = tmpl_pkg::S_WBUMP;
      tmpl_pkg::S_WBUMP:
        state_next = epoch_wrap ? tmpl_pkg::S_CLEAR : tmpl_pkg::S_WTOP;
      tmpl_pkg::S_WTOP:
        state_next = (it > ne || cur_bad) ? tmpl_pkg::S_SBUMP : tmpl_pkg::S_WCHK;
      tmpl_pkg::S_WCHK:
        if (corner_rd[0] == '0)  state_next = tmpl_pkg::S_OUT;
        else if (mark_rd == epoch) state_next = tmpl_pkg::S_SBUMP;
        else                       state_next = tmpl_pkg::S_FETCH;
      tmpl_pkg::S_SBUMP:
        state_next = epoch_wrap ? tmpl_pkg::S_CLEAR : tmpl_pkg::S_STOP;
      tmpl_pkg::S_STOP:
        state_next = (cur > ne) ? tmpl_pkg::S_OUT : tmpl_pkg::S_SCHK;
      tmpl_pkg::S_SCHK:
        state_next = (corner_rd[0] == '0) ? tmpl_pkg::S_STOP : tmpl_pkg::S_FETCH;
      tmpl_pkg::S_FETCH:
        if (fj == 3'd4) state_next = tmpl_pkg::S_PREP;
      tmpl_pkg::S_PREP:
        state_next = tmpl_pkg::S_EVAL;
      tmpl_pkg::S_EVAL:
        if (check_neg) state_next = scanning ? tmpl_pkg::S_STOP : tmpl_pkg::S_NRD;
        else if (grp_done && g == tmpl_pkg::G_DD) state_next = tmpl_pkg::S_V0;
      tmpl_pkg::S_V0:
        if (v0cnt == 2'd3) begin
          if (vol0[AW-1]) state_next = scanning ? tmpl_pkg::S_STOP : tmpl_pkg::S_NRD;
          else            state_next = tmpl_pkg::S_DIVSET;
        end
      tmpl_pkg::S_NRD:
        state_next = tmpl_pkg::S_NCAP;
      tmpl_pkg::S_NCAP:
        state_next = tmpl_pkg::S_WTOP;
      tmpl_pkg::S_DIVSET:
        state_next = (dd == '0) ? tmpl_pkg::S_OUT : tmpl_pkg::S_DIV;
      tmpl_pkg::S_DIV:
        if (qcnt == 5'd16) state_next = (k == 2'd3) ? tmpl_pkg::S_OUT : tmpl_pkg::S_DIVSET;
      tmpl_pkg::S_OUT:
        state_next = tmpl_pkg::S_IDLE;
      default:
        state_next = tmpl_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy     = (state != tmpl_pkg::S_IDLE);
    done     = (state == tmpl_pkg::S_OUT);
    issue_en = (state == tmpl_pkg::S_EVAL) && !issue_done && !check_neg;
    bary0    = bary_q[0];
    bary1    = bary_q[1];
    bary2    = bary_q[2];
    bary3    = bary_q[3];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tmpl_pkg::S_CLEAR;
      clr_ret       <= tmpl_pkg::S_IDLE;
      clr_addr      <= '0;
      epoch         <= '0;
      element_count <= '0;
      tag_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      tag_valid <= issue_en;
      if (cfg_write) element_count <= cfg_wdata;
      if (state == tmpl_pkg::S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == tmpl_pkg::S_WBUMP || state == tmpl_pkg::S_SBUMP) begin
        clr_addr <= '0;
        clr_ret  <= (state == tmpl_pkg::S_WBUMP) ? tmpl_pkg::S_WTOP : tmpl_pkg::S_STOP;
        epoch    <= epoch_wrap ? tmpl_pkg::EPOCH_W'(1) : epoch_inc;
      end
    end
  end

  // load writes and registered reads
  always_ff @(posedge clk) begin
    if (accept && kind == tmpl_pkg::KIND_VERTEX && !index[EW-1])
      vert_mem[index[EW-2:0]] <= {x, y, z};
    if (accept && kind == tmpl_pkg::KIND_SLOT && index != '0 &&
        index <= EW'(tmpl_pkg::MAX_ELEMENTS)) begin
      corner_mem[slot][index] <= corner_vertex;
      neigh_mem[slot][index]  <= face_neighbor;
    end
    for (int s = 0; s < 4; s++) corner_rd[s] <= corner_mem[s][cur];
    neigh_rd <= neigh_mem[exit_face][cur];
    vert_rd  <= vert_mem[corner_rd[fj[1:0]]];
  end

  // visit marks: clear pass or stamp
  always_ff @(posedge clk) begin
    if (state == tmpl_pkg::S_CLEAR)
      mark_mem[clr_addr] <= '0;
    else if (state == tmpl_pkg::S_WCHK)
      mark_mem[cur] <= epoch;
    mark_rd <= mark_mem[cur];
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_q   <= prod;
    tag_neg  <= pinfo.neg;
    tag_hi   <= half_sel;
    tag_last <= pinfo.last && half_sel;
    case (state)
      tmpl_pkg::S_IDLE: begin
        if (accept && kind == tmpl_pkg::KIND_QUERY) begin
          px <= x;
          py <= y;
          pz <= z;
          cur <= index;
          it <= '0;
          scanning <= 1'b0;
          ne <= (element_count > EW'(tmpl_pkg::MAX_ELEMENTS)) ?
                EW'(tmpl_pkg::MAX_ELEMENTS) : element_count;
        end
      end
      tmpl_pkg::S_SBUMP: begin
        cur <= EW'(1);
        scanning <= 1'b1;
      end
      tmpl_pkg::S_WCHK: begin
        it <= it + 1'b1;
        fj <= '0;
        if (corner_rd[0] == '0) begin
          found_element <= '0;
          for (int i = 0; i < 4; i++) bary_q[i] <= '0;
        end
      end
      tmpl_pkg::S_STOP: begin
        if (cur > ne) begin
          found_element <= '0;
          for (int i = 0; i < 4; i++) bary_q[i] <= '0;
        end
      end
      tmpl_pkg::S_SCHK: begin
        fj <= '0;
        if (corner_rd[0] == '0) cur <= cur + 1'b1;
      end
      tmpl_pkg::S_FETCH: begin
        fj <= fj + 1'b1;
        if (fj != '0) cv[fj[1:0] - 2'd1] <= vert_rd;
      end
      tmpl_pkg::S_PREP: begin
        for (int a = 0; a < 3; a++) begin
          sv[a]     <= sdiff(axis(cv[1], a), axis(cv[0], a));
          sv[3 + a] <= sdiff(axis(cv[2], a), axis(cv[0], a));
          sv[6 + a] <= sdiff(axis(cv[3], a), axis(cv[0], a));
          sv[9 + a] <= sdiff(axis({px, py, pz}, a), axis(cv[0], a));
        end
        pi <= '0;
        half_sel <= 1'b0;
        issue_done <= 1'b0;
        acc <= '0;
        g <= '0;
      end
      tmpl_pkg::S_EVAL: begin
        // advance issue
        if (issue_en) begin
          half_sel <= ~half_sel;
          if (half_sel) pi <= pi + 1'b1;
          if (half_sel && pi == 5'(tmpl_pkg::PROD_LAST)) issue_done <= 1'b1;
        end
        // accumulate and retire groups
        if (tag_valid) begin
          if (tag_last) begin
            acc <= '0;
            g <= g + 1'b1;
            case (g)
              tmpl_pkg::G_V0:   lv[0] <= acc_sum[XW-1:0];
              tmpl_pkg::G_V1:   lv[1] <= acc_sum[XW-1:0];
              tmpl_pkg::G_V2:   lv[2] <= acc_sum[XW-1:0];
              tmpl_pkg::G_VOL1: vol1  <= acc_sum;
              tmpl_pkg::G_W0:   lv[3] <= acc_sum[XW-1:0];
              tmpl_pkg::G_W1:   lv[4] <= acc_sum[XW-1:0];
              tmpl_pkg::G_W2:   lv[5] <= acc_sum[XW-1:0];
              tmpl_pkg::G_VOL2: vol2  <= acc_sum;
              tmpl_pkg::G_VOL3: vol3  <= acc_sum;
              tmpl_pkg::G_DD:   dd    <= acc_sum;
              default:          acc   <= '0;
            endcase
          end else begin
            acc <= acc_sum;
          end
        end
        v0cnt <= '0;
        if (check_neg) begin
          case (g)
            tmpl_pkg::G_VOL1: exit_face <= 2'd1;
            tmpl_pkg::G_VOL2: exit_face <= 2'd2;
            default:          exit_face <= 2'd3;
          endcase
          if (scanning) cur <= cur + 1'b1;
        end
      end
      tmpl_pkg::S_V0: begin
        v0cnt <= v0cnt + 1'b1;
        case (v0cnt)
          2'd0:    vol0 <= dd - vol1;
          2'd1:    vol0 <= vol0 - vol2;
          2'd2:    vol0 <= vol0 - vol3;
          default: begin
            k <= '0;
            exit_face <= 2'd0;
            if (vol0[AW-1] && scanning) cur <= cur + 1'b1;
          end
        endcase
      end
      tmpl_pkg::S_NCAP: begin
        cur <= neigh_rd;
      end
      tmpl_pkg::S_DIVSET: begin
        found_element <= cur;
        qcnt <= '0;
        q <= '0;
        rem <= {vol_k, 16'b0} + {(DW-AW+1)'(0), dd[AW-1:1]};
        dsh <= {dd, 16'b0};
        if (dd == '0) begin
          for (int i = 0; i < 4; i++) bary_q[i] <= '0;
        end
      end
      tmpl_pkg::S_DIV: begin
        rem  <= ge ? rem - dsh : rem;
        dsh  <= dsh >> 1;
        q    <= {q[tmpl_pkg::BARY_W-2:0], ge};
        qcnt <= qcnt + 1'b1;
        if (qcnt == 5'd16) begin
          bary_q[k] <= {q[tmpl_pkg::BARY_W-2:0], ge};
          k <= k + 1'b1;
        end
      end
      default: begin
        v0cnt <= '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == tmpl_pkg::KIND_QUERY) |=> busy)
    else $error("query accepted without going busy");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && found_element == '0) |->
      (bary0 == '0 && bary1 == '0 && bary2 == '0 && bary3 == '0))
    else $error("nonzero weights with no element found");
`endif

endmodule
